// ----- rtl/ymct_pkg.sv -----
package ymct_pkg;

    localparam int DEPTH_YEARS_DEF = 4;
    localparam int MONTHS          = 12;
    localparam int YEAR_W          = 16;
    localparam int MONTH_W         = 4;
    localparam int AMT_W           = 64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_MONTHS = 2'd2;
    localparam logic [1:0] CMD_YEARS  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_MONTH = 2'd3;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(MONTHS);

    typedef struct packed {
        logic [YEAR_W-1:0]              key;
        logic [AMT_W-1:0]               total;
        logic [MONTHS-1:0][AMT_W-1:0]   months;
    } rec_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_INIT,
        OP_ADD
    } op_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  key;
        logic [MONTH_W-1:0] month;
        logic [AMT_W-1:0]   amount;
    } bus_t;

endpackage

// ----- rtl/ymct_in_if.sv -----
interface ymct_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic [ymct_pkg::YEAR_W-1:0]    start_year;
    logic [ymct_pkg::MONTH_W-1:0]   start_month;
    logic [ymct_pkg::YEAR_W-1:0]    end_year;
    logic [ymct_pkg::MONTH_W-1:0]   end_month;
    logic signed [ymct_pkg::AMT_W-1:0] amount_in;

    modport source (output valid, cmd, start_year, start_month, end_year, end_month,
                     amount_in, input ready);
    modport sink (input valid, cmd, start_year, start_month, end_year, end_month,
                   amount_in, output ready);
endinterface

// ----- rtl/ymct_out_if.sv -----
interface ymct_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [ymct_pkg::YEAR_W-1:0]    result_year;
    logic [ymct_pkg::MONTH_W-1:0]   result_month;
    logic signed [ymct_pkg::AMT_W-1:0] amount_out;
    logic                           last;

    modport source (output valid, status, result_year, result_month, amount_out, last,
                     input ready);
    modport sink (input valid, status, result_year, result_month, amount_out, last,
                   output ready);
endinterface

// ----- rtl/ymct_cell.sv -----
module ymct_cell (
    input  logic                           clk,
    input  ymct_pkg::op_t                  op,
    input  ymct_pkg::bus_t                 bus,
    input  ymct_pkg::rec_t                 left,
    output ymct_pkg::rec_t                 rec,
    output logic [ymct_pkg::AMT_W-1:0]     month_val
);

    ymct_pkg::rec_t rec_reg;
    logic [3:0]     midx;
    logic           mok;

    assign mok  = (bus.month >= ymct_pkg::MONTH_FIRST) && (bus.month <= ymct_pkg::MONTH_LAST);
    assign midx = bus.month - ymct_pkg::MONTH_FIRST;
    assign rec  = rec_reg;
    assign month_val = mok ? rec_reg.months[midx] : '0;

    always_ff @(posedge clk)
    begin
        unique case (op)
            ymct_pkg::OP_HOLD:
            begin
                rec_reg <= rec_reg;
            end
            ymct_pkg::OP_LOAD:
            begin
                rec_reg <= left;
            end
            ymct_pkg::OP_INIT:
            begin
                rec_reg.key    <= bus.key;
                rec_reg.total  <= '0;
                rec_reg.months <= '0;
            end
            ymct_pkg::OP_ADD:
            begin
                rec_reg.total <= rec_reg.total + bus.amount;
                if (mok)
                begin
                    rec_reg.months[midx] <= rec_reg.months[midx] + bus.amount;
                end
            end
            default:
            begin
                rec_reg <= rec_reg;
            end
        endcase
    end

endmodule

// ----- rtl/year_month_counter_table_unit.sv -----
// Channel   Dir  Payload
// in_ch     in   cmd, start_year, start_month, end_year, end_month, amount_in
// out_ch    out  status, result_year, result_month, amount_out, last
//
// One item at a time; the input is ready only while the control is idle.
// Point query or error: search, then decide loads the output register; add to a present
// year: search, decide, add; add that opens a new record: search, decide, insert, add.
// A range walk: search, decide, year steps over the years visited, month steps on a monthly walk, finish.
// Reset clears the record count and the control; the record cells hold no reset.
// A result waits in the output register; a full output register stalls the walk.
module year_month_counter_table_unit #(
    parameter int DEPTH_YEARS = ymct_pkg::DEPTH_YEARS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ymct_in_if.sink       in_ch,
    ymct_out_if.source    out_ch
);

    localparam int CW = $clog2(DEPTH_YEARS + 1);
    localparam int IW = (DEPTH_YEARS > 1) ? $clog2(DEPTH_YEARS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_INSERT,
        S_ADD,
        S_WYEAR,
        S_WMONTH,
        S_FINISH
    } state_t;

    state_t state_reg;

    // captured item
    logic [1:0]                     cmd_reg;
    logic [ymct_pkg::YEAR_W-1:0]    sy_reg;
    logic [ymct_pkg::MONTH_W-1:0]   sm_reg;
    logic [ymct_pkg::YEAR_W-1:0]    ey_reg;
    logic [ymct_pkg::MONTH_W-1:0]   em_reg;
    logic [ymct_pkg::AMT_W-1:0]     amt_reg;

    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  cur_reg;
    logic                           found_reg;
    logic [ymct_pkg::MONTH_W-1:0]   m_reg;
    logic [ymct_pkg::MONTH_W-1:0]   to_reg;

    // one result held back so the final one can carry last
    logic                           pend_valid_reg;
    logic [ymct_pkg::YEAR_W-1:0]    pend_year_reg;
    logic [ymct_pkg::MONTH_W-1:0]   pend_month_reg;
    logic [ymct_pkg::AMT_W-1:0]     pend_amt_reg;

    logic                           out_valid_reg;
    logic [1:0]                     out_status_reg;
    logic [ymct_pkg::YEAR_W-1:0]    out_year_reg;
    logic [ymct_pkg::MONTH_W-1:0]   out_month_reg;
    logic [ymct_pkg::AMT_W-1:0]     out_amt_reg;
    logic                           out_last_reg;

    ymct_pkg::op_t                  ops [DEPTH_YEARS];
    ymct_pkg::rec_t                 recs [DEPTH_YEARS];
    ymct_pkg::rec_t                 lefts [DEPTH_YEARS];
    logic [ymct_pkg::AMT_W-1:0]     mvals [DEPTH_YEARS];
    ymct_pkg::bus_t                 bus;

    logic [CW-1:0]                  pos;
    logic                           found;
    logic [IW-1:0]                  sel;
    logic                           cur_in;
    logic [ymct_pkg::YEAR_W-1:0]    cur_key;
    logic [ymct_pkg::AMT_W-1:0]     cur_total;
    logic [ymct_pkg::AMT_W-1:0]     cur_mval;
    logic                           bad_sm;
    logic                           bad_em;
    logic [ymct_pkg::MONTH_W-1:0]   from_m;
    logic [ymct_pkg::MONTH_W-1:0]   to_m;
    logic                           can_push;
    logic                           in_year;

    assign in_ch.ready = (state_reg == S_IDLE);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.result_year  = out_year_reg;
    assign out_ch.result_month = out_month_reg;
    assign out_ch.amount_out   = out_amt_reg;
    assign out_ch.last         = out_last_reg;

    // search: records below the count whose key is smaller than the year
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH_YEARS; i++)
        begin
            if ((CW'(i) < count_reg) && (recs[i].key < sy_reg))
            begin
                pos = pos + CW'(1);
            end
        end
    end

    assign found = (pos < count_reg) && (recs[pos[IW-1:0]].key == sy_reg);

    assign sel       = cur_reg[IW-1:0];
    assign cur_in    = cur_reg < count_reg;
    assign cur_key   = recs[sel].key;
    assign cur_total = recs[sel].total;
    assign cur_mval  = mvals[sel];

    assign bad_sm = (sm_reg < ymct_pkg::MONTH_FIRST) || (sm_reg > ymct_pkg::MONTH_LAST);
    assign bad_em = (em_reg < ymct_pkg::MONTH_FIRST) || (em_reg > ymct_pkg::MONTH_LAST);

    assign from_m   = (cur_key == sy_reg) ? sm_reg : ymct_pkg::MONTH_FIRST;
    assign to_m     = (cur_key == ey_reg) ? em_reg : ymct_pkg::MONTH_LAST;
    assign can_push = !(pend_valid_reg && out_valid_reg);
    assign in_year  = cur_in && (cur_key >= sy_reg) && (cur_key <= ey_reg);

    assign bus.key    = sy_reg;
    assign bus.month  = (state_reg == S_WMONTH) ? m_reg : sm_reg;
    assign bus.amount = amt_reg;

    // per-cell commands: shift right past the insert point, open a record, add
    always_comb
    begin
        for (int i = 0; i < DEPTH_YEARS; i++)
        begin
            ops[i] = ymct_pkg::OP_HOLD;
            if (state_reg == S_INSERT)
            begin
                if (CW'(i) == cur_reg)
                begin
                    ops[i] = ymct_pkg::OP_INIT;
                end
                else if ((CW'(i) > cur_reg) && (CW'(i) <= count_reg))
                begin
                    ops[i] = ymct_pkg::OP_LOAD;
                end
            end
            else if ((state_reg == S_ADD) && !out_valid_reg && (CW'(i) == cur_reg))
            begin
                ops[i] = ymct_pkg::OP_ADD;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH_YEARS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign lefts[g] = '0;
            end
            else
            begin : g_link
                assign lefts[g] = recs[g-1];
            end
            ymct_cell u_cell (
                .clk       (clk),
                .op        (ops[g]),
                .bus       (bus),
                .left      (lefts[g]),
                .rec       (recs[g]),
                .month_val (mvals[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            cur_reg        <= '0;
            found_reg      <= 1'b0;
            m_reg          <= '0;
            to_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // drop the result once taken; a new load below wins
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        cmd_reg   <= in_ch.cmd;
                        sy_reg    <= in_ch.start_year;
                        sm_reg    <= in_ch.start_month;
                        ey_reg    <= in_ch.end_year;
                        em_reg    <= in_ch.end_month;
                        amt_reg   <= in_ch.amount_in;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    cur_reg        <= pos;
                    found_reg      <= found;
                    pend_valid_reg <= 1'b0;
                    state_reg      <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_year_reg  <= '0;
                        out_month_reg <= '0;
                        out_amt_reg   <= '0;
                        out_last_reg  <= 1'b1;
                        if ((cmd_reg == ymct_pkg::CMD_ADD) || (cmd_reg == ymct_pkg::CMD_QUERY))
                        begin
                            if (bad_sm)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= ymct_pkg::ST_BAD_MONTH;
                                state_reg      <= S_IDLE;
                            end
                            else if (cmd_reg == ymct_pkg::CMD_QUERY)
                            begin
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                                if (found_reg)
                                begin
                                    out_status_reg <= ymct_pkg::ST_OK;
                                    out_year_reg   <= sy_reg;
                                    out_month_reg  <= sm_reg;
                                    out_amt_reg    <= cur_mval;
                                end
                                else
                                begin
                                    out_status_reg <= ymct_pkg::ST_NOT_FOUND;
                                end
                            end
                            else if (found_reg)
                            begin
                                state_reg <= S_ADD;
                            end
                            else if (count_reg == CW'(DEPTH_YEARS))
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= ymct_pkg::ST_FULL;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_INSERT;
                            end
                        end
                        else if ((cmd_reg == ymct_pkg::CMD_MONTHS) && (bad_sm || bad_em))
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= ymct_pkg::ST_BAD_MONTH;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_WYEAR;
                        end
                    end
                end
                S_INSERT:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ymct_pkg::ST_OK;
                        out_year_reg   <= sy_reg;
                        out_month_reg  <= sm_reg;
                        out_amt_reg    <= cur_mval + amt_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_WYEAR:
                begin
                    if (!in_year)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (cmd_reg == ymct_pkg::CMD_YEARS)
                    begin
                        if (can_push)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= ymct_pkg::ST_OK;
                                out_year_reg   <= pend_year_reg;
                                out_month_reg  <= pend_month_reg;
                                out_amt_reg    <= pend_amt_reg;
                                out_last_reg   <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_year_reg  <= cur_key;
                            pend_month_reg <= '0;
                            pend_amt_reg   <= cur_total;
                            cur_reg        <= cur_reg + CW'(1);
                        end
                    end
                    else if (from_m <= to_m)
                    begin
                        m_reg     <= from_m;
                        to_reg    <= to_m;
                        state_reg <= S_WMONTH;
                    end
                    else
                    begin
                        cur_reg <= cur_reg + CW'(1);
                    end
                end
                S_WMONTH:
                begin
                    if (can_push)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= ymct_pkg::ST_OK;
                            out_year_reg   <= pend_year_reg;
                            out_month_reg  <= pend_month_reg;
                            out_amt_reg    <= pend_amt_reg;
                            out_last_reg   <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_year_reg  <= cur_key;
                        pend_month_reg <= m_reg;
                        pend_amt_reg   <= cur_mval;
                        if (m_reg == to_reg)
                        begin
                            cur_reg   <= cur_reg + CW'(1);
                            state_reg <= S_WYEAR;
                        end
                        else
                        begin
                            m_reg <= m_reg + ymct_pkg::MONTH_W'(1);
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_status_reg <= ymct_pkg::ST_OK;
                            out_year_reg   <= pend_year_reg;
                            out_month_reg  <= pend_month_reg;
                            out_amt_reg    <= pend_amt_reg;
                        end
                        else
                        begin
                            out_status_reg <= ymct_pkg::ST_NOT_FOUND;
                            out_year_reg   <= '0;
                            out_month_reg  <= '0;
                            out_amt_reg    <= '0;
                        end
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH_YEARS))
        else $error("record count beyond table depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the table");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ymct_pkg::ST_OK)) |-> out_last_reg)
        else $error("error result without last");

    a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && (state_reg == S_IDLE)) |-> 1'b0)
        else $error("held result left behind after item");
`endif

endmodule

// ----- tb/year_month_counter_table_unit_test.sv -----
module year_month_counter_table_unit_test;

    localparam int NREC    = ymct_pkg::DEPTH_YEARS_DEF;
    localparam int MONTHS  = ymct_pkg::MONTHS;
    localparam int YEAR_W  = ymct_pkg::YEAR_W;
    localparam int MONTH_W = ymct_pkg::MONTH_W;
    localparam int AMT_W   = ymct_pkg::AMT_W;

    // One expected result of the table
    typedef struct {
        logic [1:0]         status;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [AMT_W-1:0]   amount;
        logic               last;
    } table_result_t;

    // Scoreboard: mirror of the counter table plus the queue of pending results
    class counter_table_board;
        int                count;
        logic [YEAR_W-1:0] keys [NREC];
        logic [AMT_W-1:0]  totals [NREC];
        logic [AMT_W-1:0]  sums [NREC][MONTHS];
        table_result_t     pending[$];
        int                errors;
        int                results_seen;
        int                range_items;

        function new();
            count = 0;
            errors = 0;
            results_seen = 0;
            range_items = 0;
        endfunction

        function void push(logic [1:0] st, logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                           logic [AMT_W-1:0] a, logic l);
            table_result_t r;
            r.status = st;
            r.year = y;
            r.month = m;
            r.amount = a;
            r.last = l;
            pending.push_back(r);
        endfunction

        // Note an accepted item and predict what it causes
        function void note_item(logic [1:0] cmd, logic [YEAR_W-1:0] sy,
                                logic [MONTH_W-1:0] sm, logic [YEAR_W-1:0] ey,
                                logic [MONTH_W-1:0] em, logic [AMT_W-1:0] amt);
            int pos;
            int emitted;
            int first_m;
            int last_m;
            bit found;
            bit bad_sm;
            bit bad_em;
            pos = 0;
            emitted = 0;
            while (pos < count && keys[pos] < sy)
                pos++;
            found = pos < count && keys[pos] == sy;
            bad_sm = sm < 1 || sm > MONTHS;
            bad_em = em < 1 || em > MONTHS;
            if (cmd == ymct_pkg::CMD_ADD || cmd == ymct_pkg::CMD_QUERY)
            begin
                if (bad_sm)
                begin
                    push(ymct_pkg::ST_BAD_MONTH, '0, '0, '0, 1'b1);
                    return;
                end
                if (cmd == ymct_pkg::CMD_QUERY)
                begin
                    if (!found)
                        push(ymct_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
                    else
                        push(ymct_pkg::ST_OK, sy, sm, sums[pos][sm-1], 1'b1);
                    return;
                end
                if (!found)
                begin
                    if (count >= NREC)
                    begin
                        push(ymct_pkg::ST_FULL, '0, '0, '0, 1'b1);
                        return;
                    end
                    // shift the tail up one slot and open a zeroed record
                    for (int i = count; i > pos; i--)
                    begin
                        keys[i] = keys[i-1];
                        totals[i] = totals[i-1];
                        sums[i] = sums[i-1];
                    end
                    keys[pos] = sy;
                    totals[pos] = '0;
                    for (int m = 0; m < MONTHS; m++)
                        sums[pos][m] = '0;
                    count++;
                end
                totals[pos] += amt;
                sums[pos][sm-1] += amt;
                push(ymct_pkg::ST_OK, sy, sm, sums[pos][sm-1], 1'b1);
                return;
            end
            range_items++;
            if (cmd == ymct_pkg::CMD_MONTHS && (bad_sm || bad_em))
            begin
                push(ymct_pkg::ST_BAD_MONTH, '0, '0, '0, 1'b1);
                return;
            end
            for (int i = pos; i < count && keys[i] >= sy && keys[i] <= ey; i++)
            begin
                if (cmd == ymct_pkg::CMD_YEARS)
                begin
                    push(ymct_pkg::ST_OK, keys[i], '0, totals[i], 1'b0);
                    emitted++;
                end
                else
                begin
                    first_m = (keys[i] == sy) ? sm : 1;
                    last_m = (keys[i] == ey) ? em : MONTHS;
                    for (int m = first_m; m <= last_m; m++)
                    begin
                        push(ymct_pkg::ST_OK, keys[i], MONTH_W'(m), sums[i][m-1], 1'b0);
                        emitted++;
                    end
                end
            end
            if (emitted == 0)
                push(ymct_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
            else
                pending[$].last = 1'b1;
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [1:0] st, logic [YEAR_W-1:0] y,
                                   logic [MONTH_W-1:0] m, logic [AMT_W-1:0] a, logic l);
            table_result_t e;
            results_seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected result: status %0d year %0d month %0d", st, y, m);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (y !== e.year)
            begin
                $error("result_year: expected %0d, got %0d", e.year, y);
                errors++;
            end
            if (m !== e.month)
            begin
                $error("result_month: expected %0d, got %0d", e.month, m);
                errors++;
            end
            if (a !== e.amount)
            begin
                $error("amount_out: expected %h, got %h", e.amount, a);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ymct_in_if  in_ch();
    ymct_out_if out_ch();

    year_month_counter_table_unit #(.DEPTH_YEARS(NREC)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    counter_table_board board;
    bit                 stim_done;
    int                 items_sent;

    // Small pool of years so that hits, inserts and full-table errors all occur
    logic [YEAR_W-1:0] year_pool [8];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Drive one item: idle for a random gap unless no_gap is set, then hold valid until accepted
    task automatic send_item(logic [1:0] cmd, logic [YEAR_W-1:0] sy, logic [MONTH_W-1:0] sm,
                             logic [YEAR_W-1:0] ey, logic [MONTH_W-1:0] em,
                             logic [AMT_W-1:0] amt, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            @(posedge clk);
            in_ch.valid <= 1'b0;
        end
        @(posedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.start_year  <= sy;
        in_ch.start_month <= sm;
        in_ch.end_year    <= ey;
        in_ch.end_month   <= em;
        in_ch.amount_in   <= amt;
        do
            @(posedge clk);
        while (!in_ch.ready);
        // item accepted at this edge; predict it and drop valid
        board.note_item(cmd, sy, sm, ey, em, amt);
        items_sent++;
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic [YEAR_W-1:0] pick_year();
        if ($urandom_range(0, 9) == 0)
            return YEAR_W'($urandom);
        return year_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [MONTH_W-1:0] pick_month();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? MONTH_W'(0) : MONTH_W'($urandom_range(13, 15));
        return MONTH_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 4))
            0: return {1'b0, {63{1'b1}}};
            1: return {1'b1, 63'd0};
            2: return {$urandom, $urandom};
            default: return AMT_W'(signed'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Stimulus
    initial
    begin
        logic [1:0]         cmd;
        logic [YEAR_W-1:0]  sy;
        logic [YEAR_W-1:0]  ey;
        int                 sel;
        board = new();
        stim_done = 1'b0;
        items_sent = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = ymct_pkg::CMD_ADD;
        in_ch.start_year = '0;
        in_ch.start_month = ymct_pkg::MONTH_FIRST;
        in_ch.end_year = '0;
        in_ch.end_month = ymct_pkg::MONTH_FIRST;
        in_ch.amount_in = '0;
        year_pool = '{16'd0, 16'd1999, 16'd2000, 16'd2001, 16'd2024, 16'd2025,
                      16'd40000, 16'hFFFF};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, bad months, extremes, wrap, full table, ranges
        send_item(ymct_pkg::CMD_YEARS, 16'd0, ymct_pkg::MONTH_FIRST, 16'hFFFF,
                  ymct_pkg::MONTH_LAST, '0, 1'b0);
        send_item(ymct_pkg::CMD_MONTHS, 16'd0, ymct_pkg::MONTH_FIRST, 16'hFFFF,
                  ymct_pkg::MONTH_LAST, '0, 1'b0);
        send_item(ymct_pkg::CMD_QUERY, 16'd2000, 4'd5, '0, ymct_pkg::MONTH_FIRST, '0, 1'b0);
        send_item(ymct_pkg::CMD_ADD, 16'd2000, 4'd0, '0, ymct_pkg::MONTH_FIRST, 64'd5, 1'b0);
        send_item(ymct_pkg::CMD_QUERY, 16'd2000, 4'd15, '0, ymct_pkg::MONTH_FIRST, '0, 1'b0);
        send_item(ymct_pkg::CMD_ADD, 16'd2000, ymct_pkg::MONTH_LAST, '0, ymct_pkg::MONTH_FIRST,
                  {1'b0, {63{1'b1}}}, 1'b0);
        send_item(ymct_pkg::CMD_ADD, 16'd2000, ymct_pkg::MONTH_LAST, '0, ymct_pkg::MONTH_FIRST,
                  64'd1, 1'b1);
        send_item(ymct_pkg::CMD_ADD, 16'hFFFF, ymct_pkg::MONTH_FIRST, '0, ymct_pkg::MONTH_FIRST,
                  {1'b1, 63'd0}, 1'b1);
        send_item(ymct_pkg::CMD_ADD, 16'd0, 4'd6, '0, ymct_pkg::MONTH_FIRST, {64{1'b1}}, 1'b0);
        send_item(ymct_pkg::CMD_ADD, 16'd1999, 4'd2, '0, ymct_pkg::MONTH_FIRST, 64'd77, 1'b0);
        send_item(ymct_pkg::CMD_ADD, 16'd2024, 4'd2, '0, ymct_pkg::MONTH_FIRST, 64'd3, 1'b0);
        send_item(ymct_pkg::CMD_ADD, 16'd2000, 4'd3, '0, ymct_pkg::MONTH_FIRST, 64'd9, 1'b0);
        send_item(ymct_pkg::CMD_QUERY, 16'd2000, ymct_pkg::MONTH_LAST, '0,
                  ymct_pkg::MONTH_FIRST, '0, 1'b0);
        send_item(ymct_pkg::CMD_QUERY, 16'd2001, ymct_pkg::MONTH_LAST, '0,
                  ymct_pkg::MONTH_FIRST, '0, 1'b0);
        send_item(ymct_pkg::CMD_YEARS, 16'd0, 4'd0, 16'hFFFF, 4'd15, '0, 1'b0);
        send_item(ymct_pkg::CMD_MONTHS, 16'd0, ymct_pkg::MONTH_FIRST, 16'hFFFF,
                  ymct_pkg::MONTH_LAST, '0, 1'b0);
        send_item(ymct_pkg::CMD_MONTHS, 16'd1999, 4'd11, 16'd2000, 4'd2, '0, 1'b0);
        send_item(ymct_pkg::CMD_MONTHS, 16'd2000, 4'd9, 16'd2000, 4'd3, '0, 1'b0);
        send_item(ymct_pkg::CMD_MONTHS, 16'd2000, 4'd0, 16'd2000, 4'd3, '0, 1'b0);
        send_item(ymct_pkg::CMD_MONTHS, 16'd2000, 4'd1, 16'd2000, 4'd13, '0, 1'b0);
        send_item(ymct_pkg::CMD_YEARS, 16'd2001, ymct_pkg::MONTH_FIRST, 16'd1999,
                  ymct_pkg::MONTH_FIRST, '0, 1'b0);
        send_item(ymct_pkg::CMD_YEARS, 16'hFFFF, ymct_pkg::MONTH_FIRST, 16'hFFFF,
                  ymct_pkg::MONTH_FIRST, '0, 1'b0);

        // Random: mostly adds and queries on a small year pool; ranges on the pool
        for (int n = 0; n < 430; n++)
        begin
            sel = $urandom_range(0, 9);
            cmd = sel < 4 ? ymct_pkg::CMD_ADD : sel < 6 ? ymct_pkg::CMD_QUERY :
                  sel < 8 ? ymct_pkg::CMD_MONTHS : ymct_pkg::CMD_YEARS;
            sy = pick_year();
            ey = $urandom_range(0, 5) == 0 ? pick_year() : year_pool[$urandom_range(0, 7)];
            if (cmd != ymct_pkg::CMD_ADD && cmd != ymct_pkg::CMD_QUERY &&
                $urandom_range(0, 3) != 0 && sy > ey)
            begin
                // keep most ranges well ordered so the walk has work
                logic [YEAR_W-1:0] t;
                t = sy;
                sy = ey;
                ey = t;
            end
            send_item(cmd, sy, pick_month(), ey, pick_month(), pick_amount(),
                      $urandom_range(0, 3) == 0);
        end
        stim_done = 1'b1;
    end

    // Result side: random stall per result, then ready until a result is taken
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            repeat (stall)
            begin
                @(posedge clk);
                out_ch.ready <= 1'b0;
            end
            @(posedge clk);
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            board.check_result(out_ch.status, out_ch.result_year, out_ch.result_month,
                               out_ch.amount_out, out_ch.last);
            out_ch.ready <= 1'b0;
        end
    end

    // End of run: all items accepted, all results drained, then a short tail
    initial
    begin
        wait (stim_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d items (%0d range queries), checked %0d results.",
                 items_sent, board.range_items, board.results_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("year_month_counter_table_unit_test OK");
        else
            $display("year_month_counter_table_unit_test NOT OK");
        $finish;
    end

    // Hard limit well beyond the slowest correct run
    initial
    begin
        #20000000;
        $display("Timeout with %0d results outstanding.", board.pending.size());
        $display("year_month_counter_table_unit_test NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ymct_pkg.sv
rtl/ymct_in_if.sv
rtl/ymct_out_if.sv
rtl/ymct_cell.sv
rtl/year_month_counter_table_unit.sv
tb/year_month_counter_table_unit_test.sv
